>>> hdl/lot_pkg.sv
// ----------------------------------------------------------------------------
// LRU order tracker package
// Field widths, operation and status codes, and the types shared by the
// tracker, its cells and its channels.
// ----------------------------------------------------------------------------
package lot_pkg;

   localparam int OPCODE_W   = 2;
   localparam int SLOT_W     = 6;
   localparam int STATUS_W   = 2;
   localparam int OCCUPANCY_W = 7;

   // operation codes
   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TOUCH  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_EVICT  = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_ILLEGAL = 2'd2;

   // contents of one cell, handed to the next cell along the row
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
   } cell_data_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic capture;   // sample hit and tail flags
      logic shift;     // take the left neighbour's contents
      logic clear;     // drop this cell from the list
   } cell_ctl_type;

endpackage

>>> hdl/lot_if.sv
// ----------------------------------------------------------------------------
// LRU order tracker channels
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface lot_req_if;
   import lot_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [SLOT_W-1:0]   slot;

   modport source (output valid, output opcode, output slot, input ready);
   modport sink   (input valid, input opcode, input slot, output ready);
endinterface

interface lot_rsp_if;
   import lot_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [SLOT_W-1:0]      evicted_slot;
   logic [OCCUPANCY_W-1:0] occupancy;

   modport source (output valid, output status, output evicted_slot,
                   output occupancy, input ready);
   modport sink   (input valid, input status, input evicted_slot,
                   input occupancy, output ready);
endinterface

>>> hdl/lru_order_tracker.sv
// ----------------------------------------------------------------------------
// LRU order tracker
// Recency order of slots, kept in a row of cells from most to least recent.
// ----------------------------------------------------------------------------
// Each request (insert, touch or evict) passes first through the transfer,
// in which every cell compares its slot with the request and notes whether
// it is the last live cell, and then through the update, in which the row
// shifts or drops a cell and the response is loaded into the output
// register. The next request is taken as soon as the update is done, even
// while the response still waits, but not before; a stalled response
// channel holds the update until the waiting response has been transferred.
// The row holds ENTRIES cells, with the most recent slot in cell zero and
// the live cells packed at the front. Inserting a slot already present,
// touching an absent one, inserting or touching a slot at or beyond ENTRIES
// and an unknown opcode all answer with the illegal status and change
// nothing; evicting from an empty row answers with the empty status.
// Occupancy is the count after the request; the evicted slot is zero on
// every response but a successful evict. After reset the row is empty and
// requests are taken at once.
// ----------------------------------------------------------------------------
module lru_order_tracker
   import lot_pkg::*;
#(
   parameter int ENTRIES = 64
)
(
   input  logic      clock,
   input  logic      reset,
   lot_req_if.sink   req_chan,
   lot_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // sequencer states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LOOK = 1'b1;

   logic                state_ff, state_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                slot_ok_ff, slot_ok_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [SLOT_W-1:0]      evicted_ff, evicted_in;
   logic [OCCUPANCY_W-1:0] occ_ff, occ_in;

   cell_data_type     cell_data [ENTRIES];
   cell_ctl_type      cell_ctl  [ENTRIES];
   logic [ENTRIES-1:0] hit_vec;
   logic [ENTRIES-1:0] tail_vec;

   logic              req_xfer;
   logic              out_free;
   logic              update;
   logic              any_hit;
   logic [IDX_W-1:0]  hit_pos;
   logic [SLOT_W-1:0] tail_slot;
   logic              do_insert;
   logic              do_touch;
   logic              do_evict;
   cell_data_type     new_head;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign update         = (state_ff == ST_LOOK) && out_free;

   // the row of cells; cell zero is the most recent
   assign new_head.valid = 1'b1;
   assign new_head.slot  = slot_ff;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      cell_data_type left_data;
      logic          right_valid;

      if (i == 0) begin : g_first
         assign left_data = new_head;
      end else begin : g_inner
         assign left_data = cell_data[i-1];
      end

      if (i == ENTRIES - 1) begin : g_last
         assign right_valid = 1'b0;
      end else begin : g_mid
         assign right_valid = cell_data[i+1].valid;
      end

      // shift every cell on insert; on touch shift up to the matching cell,
      // which refills cell zero with the touched slot
      assign cell_ctl[i].capture = req_xfer;
      assign cell_ctl[i].shift   = update &&
                                   (do_insert || (do_touch && (IDX_W'(i) <= hit_pos)));
      assign cell_ctl[i].clear   = update && do_evict && tail_vec[i];

      lot_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl[i]),
         .req_slot    (req_chan.slot),
         .left_data   (left_data),
         .right_valid (right_valid),
         .data        (cell_data[i]),
         .hit         (hit_vec[i]),
         .tail        (tail_vec[i])
      );
   end

   // gather the flagged cells: position of the match and slot of the tail
   always_comb begin
      hit_pos   = '0;
      tail_slot = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_pos   = hit_pos   | (hit_vec[i]  ? IDX_W'(i) : '0);
         tail_slot = tail_slot | (tail_vec[i] ? cell_data[i].slot : '0);
      end
   end

   assign any_hit   = |hit_vec;
   assign do_insert = (op_ff == OP_INSERT) && slot_ok_ff && !any_hit;
   assign do_touch  = (op_ff == OP_TOUCH)  && slot_ok_ff && any_hit;
   assign do_evict  = (op_ff == OP_EVICT)  && (count_ff != '0);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      slot_in      = slot_ff;
      slot_ok_in   = slot_ok_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      status_in    = status_ff;
      evicted_in   = evicted_ff;
      occ_in       = occ_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               op_in      = req_chan.opcode;
               slot_in    = req_chan.slot;
               slot_ok_in = (32'(req_chan.slot) < ENTRIES);
               state_in   = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (out_free) begin
               // update the count on insert and evict and load the response
               evicted_in = '0;
               if (do_insert) begin
                  count_in  = count_ff + CNT_W'(1);
                  status_in = STAT_DONE;
               end else if (do_touch) begin
                  status_in = STAT_DONE;
               end else if (do_evict) begin
                  count_in   = count_ff - CNT_W'(1);
                  status_in  = STAT_DONE;
                  evicted_in = tail_slot;
               end else if (op_ff == OP_EVICT) begin
                  status_in = STAT_EMPTY;
               end else begin
                  status_in = STAT_ILLEGAL;
               end
               occ_in       = OCCUPANCY_W'(count_in);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      slot_ff    <= slot_in;
      slot_ok_ff <= slot_ok_in;
      status_ff  <= status_in;
      evicted_ff <= evicted_in;
      occ_ff     <= occ_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.evicted_slot = evicted_ff;
   assign rsp_chan.occupancy    = occ_ff;

endmodule

>>> hdl/lot_cell.sv
// ----------------------------------------------------------------------------
// LRU order tracker cell
// One position of the recency row: holds a slot index and a valid flag,
// flags a match against the request and whether it is the last live cell.
// ----------------------------------------------------------------------------
module lot_cell
   import lot_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cell_ctl_type      ctl,
   input  logic [SLOT_W-1:0] req_slot,
   input  cell_data_type     left_data,
   input  logic              right_valid,
   output cell_data_type     data,
   output logic              hit,
   output logic              tail
);

   logic              valid_ff, valid_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              hit_ff, hit_in;
   logic              tail_ff, tail_in;

   always_comb begin
      valid_in = valid_ff;
      slot_in  = slot_ff;
      hit_in   = hit_ff;
      tail_in  = tail_ff;
      if (ctl.capture) begin
         hit_in  = valid_ff && (slot_ff == req_slot);
         tail_in = valid_ff && !right_valid;
      end
      if (ctl.shift) begin
         valid_in = left_data.valid;
         slot_in  = left_data.slot;
      end else if (ctl.clear) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
         tail_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
         tail_ff  <= tail_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign data.valid = valid_ff;
   assign data.slot  = slot_ff;
   assign hit        = hit_ff;
   assign tail       = tail_ff;

endmodule

>>> hdl/lot_checker.sv
// ----------------------------------------------------------------------------
// LRU order tracker checker
// Port-level checks on the response channel, bound to the tracker.
// ----------------------------------------------------------------------------
module lot_checker
   import lot_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [STATUS_W-1:0]    rsp_status,
   input logic [SLOT_W-1:0]      rsp_evicted_slot,
   input logic [OCCUPANCY_W-1:0] rsp_occupancy
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_evicted_slot) && $stable(rsp_occupancy))
      else $error("response changed while stalled");

   // empty status only with an empty list
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_EMPTY) |-> rsp_occupancy == '0)
      else $error("empty status with nonzero occupancy");

   // evicted slot is zero on any failed operation
   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_DONE) |-> rsp_evicted_slot == '0)
      else $error("evicted slot set on a failed operation");

   // at most one slot index per cell of the six-bit slot space
   a_occ_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occupancy <= OCCUPANCY_W'(64))
      else $error("occupancy beyond the slot space");

endmodule

bind lru_order_tracker lot_checker u_lot_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_evicted_slot (rsp_chan.evicted_slot),
   .rsp_occupancy    (rsp_chan.occupancy)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU order tracker testbench
// Drives insert, touch and evict requests into the tracker through a bursty
// sender while the response side stalls in shifting patterns. A recency row
// kept here predicts each response as its request is transferred, and every
// response is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   import lot_pkg::*;

   localparam int ENTRIES     = 64;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_REQS = 1130;

   // the opcode that names no operation
   localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;

   // two copies of the recency row: one steers the stimulus as it is built,
   // the other tracks the block as requests are transferred
   localparam int PLAN_VIEW  = 0;
   localparam int TRACK_VIEW = 1;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [SLOT_W-1:0]   slot;
   } lru_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [SLOT_W-1:0]      evicted_slot;
      logic [OCCUPANCY_W-1:0] occupancy;
   } lru_response_type;

   logic clock;
   logic reset;

   lot_req_if req_if ();
   lot_rsp_if rsp_if ();

   lru_order_tracker #(.ENTRIES(ENTRIES)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // recency rows, most recent slot at index zero
   logic [SLOT_W-1:0] recency_row [2][ENTRIES];
   int unsigned       row_fill [2] = '{0, 0};

   lru_request_type  pending_requests [$];
   lru_response_type expected_responses [$];
   int unsigned      mismatch_count = 0;
   int unsigned      cycle_count = 0;
   int unsigned      response_count = 0;

   // sender and receiver pacing
   lru_request_type next_request;
   int unsigned     burst_left;
   int unsigned     gap_left;
   int unsigned     stall_mode;
   int unsigned     mode_left = 0;
   int unsigned     pattern_phase = 0;

   // -------------------------------------------------------------------------
   // Clock
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hold every block input at a known value until the first edge
   initial begin
      req_if.valid  = 1'b0;
      req_if.opcode = OP_INSERT;
      req_if.slot   = '0;
      rsp_if.ready  = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Recency prediction
   // -------------------------------------------------------------------------
   // Position of a slot in the chosen row, or -1 when it is absent.
   function automatic int find_slot(int unsigned view, logic [SLOT_W-1:0] slot);
      int pos;
      pos = -1;
      for (int i = 0; i < row_fill[view]; i++) begin
         if (recency_row[view][i] == slot) pos = i;
      end
      return pos;
   endfunction

   // Apply one request to the chosen row and return the response it causes.
   function automatic lru_response_type advance_recency(int unsigned view,
                                                        lru_request_type req);
      lru_response_type rsp;
      int               pos;
      rsp.status       = STAT_DONE;
      rsp.evicted_slot = '0;
      pos = find_slot(view, req.slot);
      case (req.opcode)
         OP_INSERT: begin
            if (pos >= 0 || int'(req.slot) >= ENTRIES) begin
               rsp.status = STAT_ILLEGAL;
            end else begin
               // shift everything one place back, then drop the slot in front
               for (int i = int'(row_fill[view]); i > 0; i--) begin
                  recency_row[view][i] = recency_row[view][i-1];
               end
               recency_row[view][0] = req.slot;
               row_fill[view]++;
            end
         end
         OP_TOUCH: begin
            if (pos < 0 || int'(req.slot) >= ENTRIES) begin
               rsp.status = STAT_ILLEGAL;
            end else begin
               // touching the head leaves the loop empty and the row as it is
               for (int i = pos; i > 0; i--) begin
                  recency_row[view][i] = recency_row[view][i-1];
               end
               recency_row[view][0] = req.slot;
            end
         end
         OP_EVICT: begin
            if (row_fill[view] == 0) begin
               rsp.status = STAT_EMPTY;
            end else begin
               row_fill[view]--;
               rsp.evicted_slot = recency_row[view][row_fill[view]];
            end
         end
         default: begin
            rsp.status = STAT_ILLEGAL;
         end
      endcase
      rsp.occupancy = OCCUPANCY_W'(row_fill[view]);
      return rsp;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus building
   // -------------------------------------------------------------------------
   task automatic queue_request(logic [OPCODE_W-1:0] opcode, logic [SLOT_W-1:0] slot);
      lru_request_type  req;
      lru_response_type ignored;
      req.opcode = opcode;
      req.slot   = slot;
      pending_requests.push_back(req);
      // keep the planning row in step so later picks know what is present
      ignored = advance_recency(PLAN_VIEW, req);
   endtask

   // A slot now in the list; any slot when the list is empty.
   function automatic logic [SLOT_W-1:0] present_slot();
      if (row_fill[PLAN_VIEW] == 0) return SLOT_W'($urandom_range(0, ENTRIES - 1));
      return recency_row[PLAN_VIEW][$urandom_range(0, row_fill[PLAN_VIEW] - 1)];
   endfunction

   // A slot not in the list; any slot when the list is full.
   function automatic logic [SLOT_W-1:0] absent_slot();
      logic [SLOT_W-1:0] slot;
      slot = SLOT_W'($urandom_range(0, ENTRIES - 1));
      if (row_fill[PLAN_VIEW] >= ENTRIES) return slot;
      while (find_slot(PLAN_VIEW, slot) >= 0) slot = slot + 1'b1;
      return slot;
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence: build the stimulus, release reset, wait for the drain
   // -------------------------------------------------------------------------
   initial begin
      int unsigned built;
      int unsigned phase_kind;
      int unsigned phase_len;
      int unsigned pick;
      int unsigned w_insert;
      int unsigned w_touch;
      int unsigned w_evict;
      int unsigned total_requests;

      reset = 1'b1;

      // directed opening: empty list, reserved opcode, extremes of the slot
      queue_request(OP_EVICT,    6'd0);    // evict on an empty list
      queue_request(OP_RESERVED, 6'd63);   // opcode that names no operation
      queue_request(OP_TOUCH,    6'd5);    // touch with nothing in the list
      queue_request(OP_INSERT,   6'd0);
      queue_request(OP_INSERT,   6'd63);
      queue_request(OP_INSERT,   6'd0);    // insert of a present slot
      queue_request(OP_TOUCH,    6'd63);   // touch of the head
      queue_request(OP_TOUCH,    6'd0);    // touch of the tail
      queue_request(OP_INSERT,   6'd21);
      queue_request(OP_INSERT,   6'd42);
      queue_request(OP_TOUCH,    6'd63);   // touch of the tail
      queue_request(OP_TOUCH,    6'd7);    // touch of an absent slot
      queue_request(OP_RESERVED, 6'd0);
      queue_request(OP_EVICT,    6'd63);
      queue_request(OP_EVICT,    6'd42);
      queue_request(OP_EVICT,    6'd21);
      queue_request(OP_EVICT,    6'd0);
      queue_request(OP_EVICT,    6'd0);    // empty again
      queue_request(OP_INSERT,   6'd33);
      queue_request(OP_TOUCH,    6'd33);   // sole slot is head and tail
      queue_request(OP_EVICT,    6'd12);   // evict the only slot
      queue_request(OP_EVICT,    6'd12);

      // Random part in phases: filling phases push the list toward full, draining
      // phases toward empty, mixed phases churn the middle of the order.
      built = 0;
      while (built < RANDOM_REQS) begin
         phase_kind = $urandom_range(0, 2);
         phase_len  = $urandom_range(40, 160);
         case (phase_kind)
            0:       begin w_insert = 65; w_touch = 25; w_evict = 8;  end
            1:       begin w_insert = 20; w_touch = 20; w_evict = 58; end
            default: begin w_insert = 35; w_touch = 35; w_evict = 28; end
         endcase
         for (int n = 0; n < phase_len && built < RANDOM_REQS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < w_insert) begin
               queue_request(OP_INSERT, ($urandom_range(0, 99) < 85) ?
                             absent_slot() : SLOT_W'($urandom_range(0, ENTRIES - 1)));
            end else if (pick < w_insert + w_touch) begin
               queue_request(OP_TOUCH, ($urandom_range(0, 99) < 85) ?
                             present_slot() : SLOT_W'($urandom_range(0, ENTRIES - 1)));
            end else if (pick < w_insert + w_touch + w_evict) begin
               queue_request(OP_EVICT, SLOT_W'($urandom_range(0, ENTRIES - 1)));
            end else begin
               queue_request(OP_RESERVED, SLOT_W'($urandom_range(0, ENTRIES - 1)));
            end
            built++;
         end
      end
      total_requests = pending_requests.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // wait until every request has had its response transferred
      while (response_count < total_requests) @(posedge clock);
      // allow a stray response a chance to show itself
      repeat (16) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("lru_order_tracker test passed");
      end else begin
         $display("lru_order_tracker test failed");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run if the responses stop coming
   // -------------------------------------------------------------------------
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("lru_order_tracker test failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Request driver
   // -------------------------------------------------------------------------
   // Present requests in bursts of random length separated by random gaps;
   // now and then a long burst runs with no gap at all. A new request is
   // loaded only once the one on the channel has been transferred.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid  <= 1'b0;
         req_if.opcode <= OP_INSERT;
         req_if.slot   <= '0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_left != 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            next_request = pending_requests.pop_front();
            req_if.valid  <= 1'b1;
            req_if.opcode <= next_request.opcode;
            req_if.slot   <= next_request.slot;
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                        : $urandom_range(1, 16);
            end
            burst_left--;
            if (burst_left == 0) begin
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response stall pattern
   // -------------------------------------------------------------------------
   // Switch between always ready, random stalls, a fixed duty pattern and
   // heavy back-pressure, each mode held for a random stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(64, 256);
         end else begin
            mode_left--;
         end
         pattern_phase++;
         case (stall_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= ($urandom_range(0, 9) < 6);
            2:       rsp_if.ready <= ((pattern_phase % 7) < 4);
            default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Monitor and checker
   // -------------------------------------------------------------------------
   // Predict on every request transfer; compare every response transfer with
   // the oldest prediction still outstanding.
   always @(posedge clock) begin
      lru_request_type  seen_req;
      lru_response_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            seen_req.opcode = req_if.opcode;
            seen_req.slot   = req_if.slot;
            expected_responses.push_back(advance_recency(TRACK_VIEW, seen_req));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            response_count++;
            if (expected_responses.size() == 0) begin
               $display("%0t: unexpected response: status %0d evicted_slot %0d occupancy %0d",
                        $realtime, rsp_if.status, rsp_if.evicted_slot, rsp_if.occupancy);
               mismatch_count++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_if.status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d actual %0d",
                           $realtime, want.status, rsp_if.status);
                  mismatch_count++;
               end
               if (rsp_if.evicted_slot !== want.evicted_slot) begin
                  $display("%0t: evicted_slot mismatch: expected %0d actual %0d",
                           $realtime, want.evicted_slot, rsp_if.evicted_slot);
                  mismatch_count++;
               end
               if (rsp_if.occupancy !== want.occupancy) begin
                  $display("%0t: occupancy mismatch: expected %0d actual %0d",
                           $realtime, want.occupancy, rsp_if.occupancy);
                  mismatch_count++;
               end
            end
         end
      end
   end

endmodule

>>> files.f
hdl/lot_pkg.sv
hdl/lot_if.sv
hdl/lot_cell.sv
hdl/lru_order_tracker.sv
hdl/lot_checker.sv
tb/testbench.sv
